### rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// shared types for the miller-rabin round: sequencer states and the
// status word of the modular multiply unit
// ----------------------------------------------------------------------------
package mrr_pkg;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLASS = 9'b000000010,
        S_SPLIT = 9'b000000100,
        S_BASE  = 9'b000001000,
        S_POW   = 9'b000010000,
        S_ACC   = 9'b000100000,
        S_SQB   = 9'b001000000,
        S_SQR   = 9'b010000000,
        S_DONE  = 9'b100000000
    } mrr_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mrr_mul_status_t;

endpackage

### rtl/mrr_modmul.sv
// ----------------------------------------------------------------------------
// mrr_modmul
// modular multiply: the product is registered at start, then a restoring
// shift-subtract reduction of the double-width product, one bit per cycle
// ----------------------------------------------------------------------------
module mrr_modmul
    import mrr_pkg::*;
#(
    parameter int W = 31
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [W-1:0]    op_a,
    input  logic [W-1:0]    op_b,
    input  logic [W-1:0]    modulus,
    output logic [W-1:0]    result,
    output mrr_mul_status_t status
);

    localparam int PW = 2 * W;
    localparam int CW = $clog2(PW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [W-1:0]  rem_reg, rem_next;

    logic [W:0]    trial;
    logic [W:0]    m_ext;
    logic [W:0]    diff;

    assign trial = {rem_reg, prod_reg[PW-1]};
    assign m_ext = {1'b0, modulus};
    assign diff  = trial - m_ext;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        if (start && !busy_reg)
        begin
            prod_next = PW'(op_a) * PW'(op_b);
            rem_next  = '0;
            cnt_next  = CW'(PW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one restoring step: remainder stays below the modulus
            rem_next  = (trial >= m_ext) ? diff[W-1:0] : trial[W-1:0];
            prod_next = prod_reg << 1;
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign result      = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### rtl/miller_rabin_round.sv
// ----------------------------------------------------------------------------
// miller_rabin_round
// one miller-rabin round: candidate n and witness base a in, verdict out
// ----------------------------------------------------------------------------
// usage
//   request channel: candidate and base with req_valid; a request is taken
//   when req_valid is high and req_stall is low. req_stall is high for the
//   whole time a request is being worked on, so one request is in flight.
//   result channel: probable_prime with res_valid; taken when res_valid is
//   high and res_stall is low. the verdict sits in an output register, so
//   the next request is taken while an earlier verdict still waits.
//   cost: n below 2, n equal to 2 and even n are decided without a
//   multiplication. odd n >= 3 takes M = 1 + bitlen(u) + popcount(u) + t
//   modular multiplications, where n - 1 = u * 2^t, done one after another
//   on the single shared modular multiplier with its bit-serial reduction;
//   for 31-bit candidates it is up to 62 multiplications.
//   a stalled result blocks the finish of the following request only.
//   reset: asynchronous, active low; the block comes up idle with no result
//   pending. there is no other state and no configuration.
// ----------------------------------------------------------------------------
module miller_rabin_round
    import mrr_pkg::*;
#(
    parameter int NUM_BITS = 31
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [NUM_BITS-1:0] candidate,
    input  logic [NUM_BITS-1:0] base,
    output logic                res_valid,
    input  logic                res_stall,
    output logic                probable_prime
);

    localparam int W  = NUM_BITS;
    localparam int TW = $clog2(NUM_BITS);

    mrr_state_t      state_reg, state_next;
    logic [W-1:0]    n_reg, n_next;
    logic [W-1:0]    a_reg, a_next;
    logic [W-1:0]    b_reg, b_next;     // base power a^(2^k) mod n
    logic [W-1:0]    x_reg, x_next;     // accumulator, later the root under test
    logic [W-1:0]    u_reg, u_next;     // remaining exponent bits
    logic [TW-1:0]   t_reg, t_next;     // count of twos in n - 1
    logic [TW-1:0]   sq_reg, sq_next;   // squarings left
    logic            verdict_reg, verdict_next;
    logic            res_valid_reg, res_valid_next;
    logic            prime_reg, prime_next;

    logic            mul_start;
    logic [W-1:0]    mul_a;
    logic [W-1:0]    mul_b;
    logic [W-1:0]    mul_result;
    mrr_mul_status_t mul_status;

    logic [W-1:0]    n_minus_1;
    logic            out_free;

    assign n_minus_1 = n_reg - W'(1);
    assign out_free  = !res_valid_reg || !res_stall;

    mrr_modmul #(
        .W (W)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (n_reg),
        .result  (mul_result),
        .status  (mul_status)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        x_next       = x_reg;
        u_next       = u_reg;
        t_next       = t_reg;
        sq_next      = sq_reg;
        verdict_next = verdict_reg;
        mul_start    = 1'b0;
        mul_a        = x_reg;
        mul_b        = x_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    n_next     = candidate;
                    a_next     = base;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                // trivial candidates decided without the base
                if (n_reg < W'(2))
                begin
                    verdict_next = 1'b0;
                    state_next   = S_DONE;
                end
                else if (n_reg == W'(2))
                begin
                    verdict_next = 1'b1;
                    state_next   = S_DONE;
                end
                else if (!n_reg[0])
                begin
                    verdict_next = 1'b0;
                    state_next   = S_DONE;
                end
                else
                begin
                    u_next     = n_minus_1;
                    t_next     = '0;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (u_reg[0])
                begin
                    // reduce the base: a * 1 mod n
                    mul_start  = 1'b1;
                    mul_a      = a_reg;
                    mul_b      = W'(1);
                    state_next = S_BASE;
                end
                else
                begin
                    u_next = u_reg >> 1;
                    t_next = t_reg + TW'(1);
                end
            end
            S_BASE:
            begin
                if (mul_status.done)
                begin
                    b_next     = mul_result;
                    x_next     = W'(1);
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                if (u_reg == '0)
                begin
                    mul_start  = 1'b1;
                    mul_a      = x_reg;
                    mul_b      = x_reg;
                    sq_next    = t_reg;
                    state_next = S_SQR;
                end
                else if (u_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_a      = x_reg;
                    mul_b      = b_reg;
                    state_next = S_ACC;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = b_reg;
                    mul_b      = b_reg;
                    state_next = S_SQB;
                end
            end
            S_ACC:
            begin
                if (mul_status.done)
                begin
                    x_next     = mul_result;
                    mul_start  = 1'b1;
                    mul_a      = b_reg;
                    mul_b      = b_reg;
                    state_next = S_SQB;
                end
            end
            S_SQB:
            begin
                if (mul_status.done)
                begin
                    b_next     = mul_result;
                    u_next     = u_reg >> 1;
                    state_next = S_POW;
                end
            end
            S_SQR:
            begin
                if (mul_status.done)
                begin
                    x_next  = mul_result;
                    sq_next = sq_reg - TW'(1);
                    // nontrivial square root of one
                    if (mul_result == W'(1) && x_reg != W'(1) && x_reg != n_minus_1)
                    begin
                        verdict_next = 1'b0;
                        state_next   = S_DONE;
                    end
                    else if (sq_reg == TW'(1))
                    begin
                        verdict_next = (mul_result == W'(1));
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        mul_start = 1'b1;
                        mul_a     = mul_result;
                        mul_b     = mul_result;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        prime_next     = prime_reg;
        if (state_reg == S_DONE && out_free)
        begin
            res_valid_next = 1'b1;
            prime_next     = verdict_reg;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        x_reg       <= x_next;
        u_reg       <= u_next;
        t_reg       <= t_next;
        sq_reg      <= sq_next;
        verdict_reg <= verdict_next;
        prime_reg   <= prime_next;
    end

    assign req_stall      = (state_reg != S_IDLE);
    assign res_valid      = res_valid_reg;
    assign probable_prime = prime_reg;

    // multiply unit is only started when free
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_status.busy)
        else $error("multiply started while busy");

    // a finished multiply is only seen in a state that waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_status.done |-> (state_reg == S_BASE || state_reg == S_ACC ||
                             state_reg == S_SQB || state_reg == S_SQR))
        else $error("multiply result with nobody waiting");

    // reduced operands stay below the modulus during exponentiation
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POW) |-> (b_reg < n_reg && x_reg < n_reg))
        else $error("operand not reduced");

    // squaring phase always has at least one squaring left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQR) |-> (sq_reg != '0))
        else $error("squaring count ran out");

endmodule
